>>> design/omct_pkg.sv
package omct_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENTRY_W = 32 + 32 + 32 + 64 + 64 + 64;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] mean_x;
    logic [31:0] mean_y;
    logic [63:0] sum_sq_x;
    logic [63:0] sum_sq_y;
    logic [63:0] co_moment;
  } entry_t;

  // Divider request and result between sequencer and divider
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [32:0] mag;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] quot;
  } div_rsp_t;

  // Saturating signed 64-bit add
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    begin
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
        sat_add = a[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      end else begin
        sat_add = s;
      end
    end
  endfunction

endpackage

>>> design/omct_ram.sv
module omct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/omct_div.sv
module omct_div (
  input  logic             clk,
  input  logic             rst,
  input  omct_pkg::div_req_t req,
  output omct_pkg::div_rsp_t rsp
);

  // Restoring division, one quotient bit per cycle; signed result truncates toward zero
  logic [32:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic        fin;
  logic [33:0] trial;
  logic [32:0] rem_sh;

  always_comb begin
    rem_sh = {rem[31:0], quo[32]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs};
  end

  // 33 steps, then the signed quotient is registered with a single done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= fin;
      fin      <= busy && (cnt == 6'd1);
      if (fin) begin
        rsp.quot <= neg ? -{1'b0, quo} : {1'b0, quo};
      end
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.mag;
        rem  <= '0;
        dvs  <= req.divisor;
        neg  <= req.neg;
        cnt  <= 6'd33;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> design/online_mean_covariance_table.sv
// Online mean and covariance table (bivariate Welford accumulators).
// Input channel: in_valid/in_ready carry slot, x_value, y_value (Q16.16).
// Output channel: out_valid/out_ready carry the updated slot accumulator:
// sample_count, mean_x, mean_y, sum_sq_x, sum_sq_y, co_moment.
// One item at a time: in_ready is low from the transfer until the result
// has been written into the output register. The item passes the table
// read, two 33-step serial divisions (mean updates, each with issue and
// handoff) and three 32x32 magnitude products, each built from four 17x17
// partial products on one shared multiplier, then the write-back; the next
// transfer can follow in the cycle after the result is loaded.
// The next item is accepted while a finished result waits in the output
// register; it stalls only at its end if out_ready is still low.
// After rst a clearing pass writes zero to all SLOT_COUNT table rows,
// one row a cycle; in_ready stays low meanwhile.
// A slot at or beyond SLOT_COUNT returns all-zero fields, state unchanged.
module online_mean_covariance_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  slot,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sample_count,
  output logic signed [31:0] mean_x,
  output logic signed [31:0] mean_y,
  output logic signed [63:0] sum_sq_x,
  output logic signed [63:0] sum_sq_y,
  output logic signed [63:0] co_moment
);

  localparam int SW = omct_pkg::SLOT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD, S_DIVX, S_WAITX, S_DIVY, S_WAITY,
    S_PREP, S_MUL, S_ACC, S_WRITE, S_OUT
  } state_t;

  state_t state;

  // Table memory
  logic                        ram_we;
  logic [SW-1:0]               ram_waddr;
  logic [omct_pkg::ENTRY_W-1:0] ram_wdata;
  logic [omct_pkg::ENTRY_W-1:0] ram_rdata;
  logic [SW-1:0]               clr_addr;
  logic [SW-1:0]               s_addr;
  logic                        s_oob;

  // Item registers
  logic signed [32:0] x_r;
  logic signed [32:0] y_r;
  omct_pkg::entry_t   ent;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] mx;
  logic signed [32:0] my;

  // Divider
  omct_pkg::div_req_t dreq;
  omct_pkg::div_rsp_t drsp;

  // Multiplier sequencing: term index 0..2, partial index 0..3
  logic [1:0]  term;
  logic [1:0]  part;
  logic [31:0] ma;
  logic [31:0] mb;
  logic        mneg;
  logic [63:0] macc;
  logic [33:0] pprod;
  logic [16:0] pa;
  logic [16:0] pb;
  logic [63:0] pshift;

  logic signed [32:0] opa;
  logic signed [32:0] opb;

  omct_ram #(.WIDTH(omct_pkg::ENTRY_W), .DEPTH(omct_pkg::SLOT_COUNT)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(s_addr),
    .rdata(ram_rdata)
  );

  omct_div u_div (
    .clk(clk),
    .rst(rst),
    .req(dreq),
    .rsp(drsp)
  );

  assign in_ready = (state == S_IDLE);

  // Operand select for the product terms
  always_comb begin
    case (term)
      2'd0:    begin opa = dx; opb = x_r - mx; end
      2'd1:    begin opa = dy; opb = y_r - my; end
      default: begin opa = dx; opb = y_r - my; end
    endcase
  end

  // One 17x17 partial product per cycle
  always_comb begin
    pa = part[0] ? {1'b0, ma[31:16]} : {1'b0, ma[15:0]};
    pb = part[1] ? {1'b0, mb[31:16]} : {1'b0, mb[15:0]};
    pprod = {17'd0, pa} * {17'd0, pb};
    case (part)
      2'd0:    pshift = {30'd0, pprod};
      2'd1:    pshift = {14'd0, pprod, 16'd0};
      2'd2:    pshift = {14'd0, pprod, 16'd0};
      default: pshift = {pprod[31:0], 32'd0};
    endcase
  end

  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_WRITE && !s_oob);
    ram_waddr = (state == S_CLEAR) ? clr_addr : s_addr;
    ram_wdata = (state == S_CLEAR) ? '0 : ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      dreq      <= '0;
      term      <= '0;
      part      <= '0;
    end else begin
      // Divider start pulses while leaving the issue states
      dreq.start <= (state == S_DIVX) || (state == S_DIVY);
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SW'(omct_pkg::SLOT_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            s_addr <= slot[SW-1:0];
            s_oob  <= (32'(slot) >= omct_pkg::SLOT_COUNT);
            x_r    <= 33'(x_value);
            y_r    <= 33'(y_value);
            state  <= S_READ;
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          // Count saturates at all ones
          ent <= {(ram_rdata[omct_pkg::ENTRY_W-1 -: 32] != 32'hffff_ffff) ?
                  ram_rdata[omct_pkg::ENTRY_W-1 -: 32] + 32'd1 :
                  ram_rdata[omct_pkg::ENTRY_W-1 -: 32],
                  ram_rdata[omct_pkg::ENTRY_W-33:0]};
          state <= S_DIVX;
        end
        S_DIVX: begin
          dx           <= x_r - 33'($signed(ent.mean_x));
          dy           <= y_r - 33'($signed(ent.mean_y));
          dreq.neg     <= (x_r < 33'($signed(ent.mean_x)));
          dreq.mag     <= (x_r < 33'($signed(ent.mean_x))) ?
                          33'($signed(ent.mean_x)) - x_r : x_r - 33'($signed(ent.mean_x));
          dreq.divisor <= ent.count;
          state        <= S_WAITX;
        end
        S_WAITX: begin
          if (drsp.done) begin
            mx    <= 33'($signed(ent.mean_x)) + drsp.quot[32:0];
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          dreq.neg   <= dy[32];
          dreq.mag   <= dy[32] ? -dy : dy;
          state      <= S_WAITY;
        end
        S_WAITY: begin
          if (drsp.done) begin
            my    <= 33'($signed(ent.mean_y)) + drsp.quot[32:0];
            term  <= 2'd0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // Magnitudes stay below 2^32
          mneg  <= opa[32] ^ opb[32];
          ma    <= opa[32] ? 32'(-opa) : opa[31:0];
          mb    <= opb[32] ? 32'(-opb) : opb[31:0];
          macc  <= '0;
          part  <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          macc <= macc + pshift;
          part <= part + 2'd1;
          if (part == 2'd3) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          case (term)
            2'd0: ent.sum_sq_x <= omct_pkg::sat_add(ent.sum_sq_x,
                    mneg ? -{16'd0, macc[63:16]} : {16'd0, macc[63:16]});
            2'd1: ent.sum_sq_y <= omct_pkg::sat_add(ent.sum_sq_y,
                    mneg ? -{16'd0, macc[63:16]} : {16'd0, macc[63:16]});
            default: ent.co_moment <= omct_pkg::sat_add(ent.co_moment,
                    mneg ? -{16'd0, macc[63:16]} : {16'd0, macc[63:16]});
          endcase
          if (term == 2'd2) begin
            ent.mean_x <= mx[31:0];
            ent.mean_y <= my[31:0];
            state      <= S_WRITE;
          end else begin
            term  <= term + 2'd1;
            state <= S_PREP;
          end
        end
        S_WRITE: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            sample_count <= s_oob ? '0 : ent.count;
            mean_x       <= s_oob ? '0 : ent.mean_x;
            mean_y       <= s_oob ? '0 : ent.mean_y;
            sum_sq_x     <= s_oob ? '0 : ent.sum_sq_x;
            sum_sq_y     <= s_oob ? '0 : ent.sum_sq_y;
            co_moment    <= s_oob ? '0 : ent.co_moment;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT)) else $error("stray result");
  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid) else $error("result during clear");

endmodule
